// File: rtl/core/abdt_pkg.sv
// Shared constants, field widths and divider handshake types for the
// accelerometer baseline drift tracker.
// No dependencies; compiled first.
package abdt_pkg;

   // calibration length and the counters that follow from it
   localparam int CAL_SAMPLES = 1000;
   localparam int CAL_CNT_W   = $clog2(CAL_SAMPLES + 1);

   // field widths
   localparam int SAMPLE_W  = 15;
   localparam int CAL_SUM_W = SAMPLE_W + CAL_CNT_W;
   localparam int SEC_W     = 32;
   localparam int HOLD_W    = 8;
   localparam int THR_W     = 14;
   localparam int EVENT_W   = 21;
   localparam int E_W       = 13;   // event in 0.01 g
   localparam int BASE_W    = 24;   // baseline in 1/256 mg, bounded to +-2^22
   localparam int MEAN_W    = 22;   // run mean in 1/256 of 0.01 g
   localparam int RSUM_W    = 29;
   localparam int RCNT_W    = 16;

   // serial divider sizing
   localparam int MAG_W  = 38;
   localparam int DEN_W  = 16;
   localparam int REM_W  = DEN_W + 1;
   localparam int N_W    = MAG_W + 2;
   localparam int QUOT_W = 23;
   localparam int QCNT_W = 5;

   // quotient lengths per division kind
   localparam logic [QCNT_W-1:0] QBITS_CAL  = QCNT_W'(23);
   localparam logic [QCNT_W-1:0] QBITS_EV   = QCNT_W'(13);
   localparam logic [QCNT_W-1:0] QBITS_MEAN = QCNT_W'(21);

   localparam logic [DEN_W-1:0]  CAL_DEN  = DEN_W'(CAL_SAMPLES);
   localparam logic [DEN_W-1:0]  EV_DEN   = DEN_W'(2560);
   localparam logic [RCNT_W-1:0] RCNT_MAX = '1;

   localparam int BASE_LIM = 4194304;
   localparam int EV_MAX   = 1048575;
   localparam int EV_MIN   = -1048576;

   // register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 14;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR  = 1'b1;
   localparam logic [HOLD_W-1:0]    HOLD_RESET = HOLD_W'(2);
   localparam logic [THR_W-1:0]     THR_RESET  = THR_W'(500);

   // axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // divider request and response
   typedef struct packed {
      logic              start;
      logic [MAG_W-1:0]  mag;
      logic [DEN_W-1:0]  den;
      logic [QCNT_W-1:0] qbits;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

// File: rtl/core/abdt_if.sv
// Valid/ready channel interfaces for sample words in and result words out.
// Depends on abdt_pkg for field widths.
interface abdt_req_if
   import abdt_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_x;
   logic signed [SAMPLE_W-1:0] sample_y;
   logic signed [SAMPLE_W-1:0] sample_z;
   logic [SEC_W-1:0]           seconds;

   modport source (output valid, output sample_x, output sample_y, output sample_z,
                   output seconds, input ready);
   modport sink (input valid, input sample_x, input sample_y, input sample_z,
                 input seconds, output ready);
endinterface

interface abdt_rsp_if
   import abdt_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      calibrating;
   logic [1:0]                vertical_axis;
   logic signed [EVENT_W-1:0] event_first;
   logic signed [EVENT_W-1:0] event_second;
   logic                      adjusted_first;
   logic                      adjusted_second;

   modport source (output valid, output calibrating, output vertical_axis,
                   output event_first, output event_second, output adjusted_first,
                   output adjusted_second, input ready);
   modport sink (input valid, input calibrating, input vertical_axis,
                 input event_first, input event_second, input adjusted_first,
                 input adjusted_second, output ready);
endinterface

// File: rtl/core/accel_baseline_drift_tracker.sv
// Accelerometer baseline drift tracker: calibration, horizontal events and
// baseline re-centring. Depends on abdt_pkg, abdt_if and abdt_div.
//
// Usage:
//   req_ch carries one sample word (x, y, z in mg, seconds); rsp_ch returns
//   one result word per sample. Both are valid/ready; a word moves on a
//   clock edge with valid and ready high. csr_wr_en/csr_index/csr_wr_data
//   write hold_seconds (index 0) and vertical_threshold_mg (index 1).
//   The first CAL_SAMPLES words only build the baselines; with the last one
//   the three baselines are divided out. After that each word divides out
//   both horizontal events, plus a run mean for each horizontal baseline
//   that is re-centred. The bit-serial divider gives 13 quotient bits per
//   event, 21 per run mean and 23 per baseline.
//   One word is worked on at a time; the next is taken as soon as the
//   current one has moved to the result register, even if that result is
//   still waiting for the receiver. A stalled receiver holds rsp_ch and,
//   once the next result is ready, req_ch.ready stays low.
//   Reset (synchronous, active high) restores the register defaults,
//   restarts calibration and empties the result register.
module accel_baseline_drift_tracker
   import abdt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   abdt_req_if.sink              req_ch,
   abdt_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int DIFF_W  = BASE_W + 1;
   localparam int BSUM_W  = BASE_W + 2;
   localparam int RES_W   = EVENT_W + 2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CAL_MAG, ST_EV_MAG, ST_MEAN_MAG, ST_DIV_GO, ST_DIV_WAIT,
      ST_RUN_UPD, ST_APPLY, ST_OUT
   } state_type;

   typedef enum logic [1:0] {OP_CAL, OP_EV, OP_MEAN} op_type;

   // pick the horizontal axis for event slot idx
   function automatic logic [1:0] horiz_axis(input logic [1:0] vaxis, input logic idx);
      logic [1:0] a;
      case (vaxis)
         AXIS_X:  a = idx ? AXIS_Z : AXIS_Y;
         AXIS_Y:  a = idx ? AXIS_Z : AXIS_X;
         default: a = idx ? AXIS_Y : AXIS_X;
      endcase
      return a;
   endfunction

   // control and architectural state
   state_type                   state_ff, state_in;
   op_type                      op_ff, op_in;
   logic [HOLD_W-1:0]           hold_ff, hold_in;
   logic [THR_W-1:0]            thr_ff, thr_in;
   logic [CAL_CNT_W-1:0]        cal_cnt_ff, cal_cnt_in;
   logic signed [CAL_SUM_W-1:0] cal_sum_ff [3];
   logic signed [CAL_SUM_W-1:0] cal_sum_in [3];
   logic signed [BASE_W-1:0]    base_ff [3];
   logic signed [BASE_W-1:0]    base_in [3];
   logic [1:0]                  vidx_ff, vidx_in;
   logic                        first_ff [2];
   logic                        first_in [2];
   logic signed [E_W-1:0]       prior_ff [2];
   logic signed [E_W-1:0]       prior_in [2];
   logic signed [RSUM_W-1:0]    rsum_ff [2];
   logic signed [RSUM_W-1:0]    rsum_in [2];
   logic [RCNT_W-1:0]           rcnt_ff [2];
   logic [RCNT_W-1:0]           rcnt_in [2];
   logic [SEC_W-1:0]            chg_ff [2];
   logic [SEC_W-1:0]            chg_in [2];
   logic                        axis_ff, axis_in;
   logic [1:0]                  cal_axis_ff, cal_axis_in;
   logic                        cal_flag_ff, cal_flag_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // working payload
   logic signed [SAMPLE_W-1:0]  s_ff [3];
   logic signed [SAMPLE_W-1:0]  s_in [3];
   logic [SEC_W-1:0]            now_ff, now_in;
   logic [MAG_W-1:0]            mag_ff, mag_in;
   logic [DEN_W-1:0]            den_ff, den_in;
   logic [QCNT_W-1:0]           qbits_ff, qbits_in;
   logic                        neg_ff, neg_in;
   logic signed [E_W-1:0]       e_ff, e_in;
   logic signed [MEAN_W-1:0]    mean_ff, mean_in;
   logic signed [EVENT_W-1:0]   ev_out_ff [2];
   logic signed [EVENT_W-1:0]   ev_out_in [2];
   logic                        adj_out_ff [2];
   logic                        adj_out_in [2];
   logic                        rsp_cal_ff, rsp_cal_in;
   logic [1:0]                  rsp_vaxis_ff, rsp_vaxis_in;
   logic signed [EVENT_W-1:0]   rsp_ev_ff [2];
   logic signed [EVENT_W-1:0]   rsp_ev_in [2];
   logic                        rsp_adj_ff [2];
   logic                        rsp_adj_in [2];

   // combinational helpers
   logic                        req_fire;
   logic                        cal_done;
   logic [1:0]                  p_axis;
   logic signed [DIFF_W-1:0]    ev_a, ev_b;
   logic                        ev_neg;
   logic [DIFF_W-1:0]           ev_mag;
   logic signed [CAL_SUM_W-1:0] cal_sel;
   logic [CAL_SUM_W-1:0]        cal_abs;
   logic signed [RSUM_W-1:0]    rs_sel;
   logic [RSUM_W-1:0]           rs_abs;
   logic                        e_pos, e_neg, pr_pos, pr_neg;
   logic                        restart, adjust;
   logic [SEC_W-1:0]            hold_gap;
   logic signed [RSUM_W-1:0]    rsum_base;
   logic [RCNT_W-1:0]           rcnt_base;
   logic [QUOT_W-1:0]           q;
   logic signed [BSUM_W-1:0]    mean_w, base_sum;
   logic signed [RES_W-1:0]     res_w;
   logic signed [BASE_W-1:0]    base_clamp;
   logic signed [EVENT_W-1:0]   res_clamp;

   div_req_type div_req;
   div_rsp_type div_rsp;

   abdt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign div_req.start = (state_ff == ST_DIV_GO);
   assign div_req.mag   = mag_ff;
   assign div_req.den   = den_ff;
   assign div_req.qbits = qbits_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign cal_done     = (cal_cnt_ff == CAL_CNT_W'(CAL_SAMPLES));
   assign p_axis       = horiz_axis(vidx_ff, axis_ff);
   assign q            = div_rsp.quot;

   // event operand: |sample*256 - baseline| with its sign
   always_comb begin
      ev_a   = DIFF_W'(s_ff[p_axis]) <<< 8;
      ev_b   = DIFF_W'(base_ff[p_axis]);
      ev_neg = ev_a < ev_b;
      ev_mag = ev_neg ? DIFF_W'(ev_b - ev_a) : DIFF_W'(ev_a - ev_b);
   end

   // calibration and run-mean magnitudes
   always_comb begin
      cal_sel = cal_sum_ff[cal_axis_ff];
      cal_abs = cal_sel[CAL_SUM_W-1] ? CAL_SUM_W'(-cal_sel) : CAL_SUM_W'(cal_sel);
      rs_sel  = rsum_ff[axis_ff];
      rs_abs  = rs_sel[RSUM_W-1] ? RSUM_W'(-rs_sel) : RSUM_W'(rs_sel);
   end

   // sign change and hold test for the current slot
   always_comb begin
      e_pos     = !e_ff[E_W-1] && (e_ff != '0);
      e_neg     = e_ff[E_W-1];
      pr_pos    = !prior_ff[axis_ff][E_W-1] && (prior_ff[axis_ff] != '0);
      pr_neg    = prior_ff[axis_ff][E_W-1];
      restart   = first_ff[axis_ff] || (!pr_pos && e_pos) || (!pr_neg && e_neg);
      rsum_base = restart ? '0 : rsum_ff[axis_ff];
      rcnt_base = restart ? '0 : rcnt_ff[axis_ff];
      hold_gap  = now_ff - chg_ff[axis_ff];
      adjust    = !restart && (hold_gap > SEC_W'(hold_ff));
   end

   // re-centring: baseline + 10*mean, event*256 - mean, both bounded
   always_comb begin
      mean_w   = BSUM_W'(mean_ff);
      base_sum = BSUM_W'(base_ff[p_axis]) + (mean_w <<< 3) + (mean_w <<< 1);
      if (base_sum > BASE_LIM) begin
         base_clamp = BASE_W'(BASE_LIM);
      end else if (base_sum < -BASE_LIM) begin
         base_clamp = BASE_W'(-BASE_LIM);
      end else begin
         base_clamp = BASE_W'(base_sum);
      end
      res_w = (RES_W'(e_ff) <<< 8) - RES_W'(mean_ff);
      if (res_w > EV_MAX) begin
         res_clamp = EVENT_W'(EV_MAX);
      end else if (res_w < EV_MIN) begin
         res_clamp = EVENT_W'(EV_MIN);
      end else begin
         res_clamp = EVENT_W'(res_w);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      hold_in      = hold_ff;
      thr_in       = thr_ff;
      cal_cnt_in   = cal_cnt_ff;
      cal_sum_in   = cal_sum_ff;
      base_in      = base_ff;
      vidx_in      = vidx_ff;
      first_in     = first_ff;
      prior_in     = prior_ff;
      rsum_in      = rsum_ff;
      rcnt_in      = rcnt_ff;
      chg_in       = chg_ff;
      axis_in      = axis_ff;
      cal_axis_in  = cal_axis_ff;
      cal_flag_in  = cal_flag_ff;
      s_in         = s_ff;
      now_in       = now_ff;
      mag_in       = mag_ff;
      den_in       = den_ff;
      qbits_in     = qbits_ff;
      neg_in       = neg_ff;
      e_in         = e_ff;
      mean_in      = mean_ff;
      ev_out_in    = ev_out_ff;
      adj_out_in   = adj_out_ff;
      rsp_cal_in   = rsp_cal_ff;
      rsp_vaxis_in = rsp_vaxis_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_adj_in   = rsp_adj_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      // register writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HOLD: hold_in = csr_wr_data[HOLD_W-1:0];
            CSR_THR:  thr_in  = csr_wr_data;
            default:  ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               s_in[0] = req_ch.sample_x;
               s_in[1] = req_ch.sample_y;
               s_in[2] = req_ch.sample_z;
               now_in  = req_ch.seconds;
               if (!cal_done) begin
                  cal_sum_in[0] = cal_sum_ff[0] + CAL_SUM_W'(req_ch.sample_x);
                  cal_sum_in[1] = cal_sum_ff[1] + CAL_SUM_W'(req_ch.sample_y);
                  cal_sum_in[2] = cal_sum_ff[2] + CAL_SUM_W'(req_ch.sample_z);
                  cal_cnt_in    = cal_cnt_ff + CAL_CNT_W'(1);
                  cal_flag_in   = 1'b1;
                  if (cal_cnt_ff == CAL_CNT_W'(CAL_SAMPLES - 1)) begin
                     vidx_in     = AXIS_Z;
                     cal_axis_in = AXIS_X;
                     state_in    = ST_CAL_MAG;
                  end else begin
                     state_in = ST_OUT;
                  end
               end else begin
                  cal_flag_in = 1'b0;
                  axis_in     = 1'b0;
                  state_in    = ST_EV_MAG;
               end
            end
         end
         ST_CAL_MAG: begin
            mag_in   = MAG_W'(cal_abs) << 8;
            neg_in   = cal_sel[CAL_SUM_W-1];
            den_in   = CAL_DEN;
            qbits_in = QBITS_CAL;
            op_in    = OP_CAL;
            state_in = ST_DIV_GO;
         end
         ST_EV_MAG: begin
            mag_in   = MAG_W'(ev_mag);
            neg_in   = ev_neg;
            den_in   = EV_DEN;
            qbits_in = QBITS_EV;
            op_in    = OP_EV;
            state_in = ST_DIV_GO;
         end
         ST_MEAN_MAG: begin
            mag_in   = MAG_W'(rs_abs) << 8;
            neg_in   = rs_sel[RSUM_W-1];
            den_in   = rcnt_ff[axis_ff];
            qbits_in = QBITS_MEAN;
            op_in    = OP_MEAN;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               case (op_ff)
                  OP_CAL: begin
                     base_in[cal_axis_ff] = neg_ff ? -BASE_W'(q) : BASE_W'(q);
                     if (q > QUOT_W'({thr_ff, 8'd0})) begin
                        vidx_in = cal_axis_ff;
                     end
                     if (cal_axis_ff == AXIS_Z) begin
                        state_in = ST_OUT;
                     end else begin
                        cal_axis_in = cal_axis_ff + 2'd1;
                        state_in    = ST_CAL_MAG;
                     end
                  end
                  OP_EV: begin
                     e_in     = neg_ff ? -E_W'(q) : E_W'(q);
                     state_in = ST_RUN_UPD;
                  end
                  OP_MEAN: begin
                     mean_in  = neg_ff ? -MEAN_W'(q) : MEAN_W'(q);
                     state_in = ST_APPLY;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_RUN_UPD: begin
            // restart the run on first use, on a sign change or after a re-centring
            if (restart) begin
               first_in[axis_ff] = 1'b0;
               chg_in[axis_ff]   = now_ff;
            end
            prior_in[axis_ff] = e_ff;
            rsum_in[axis_ff]  = rsum_base;
            rcnt_in[axis_ff]  = rcnt_base;
            if (rcnt_base != RCNT_MAX) begin
               rsum_in[axis_ff] = rsum_base + RSUM_W'(e_ff);
               rcnt_in[axis_ff] = rcnt_base + RCNT_W'(1);
            end
            ev_out_in[axis_ff]  = EVENT_W'(e_ff) <<< 8;
            adj_out_in[axis_ff] = 1'b0;
            if (adjust) begin
               state_in = ST_MEAN_MAG;
            end else if (axis_ff) begin
               state_in = ST_OUT;
            end else begin
               axis_in  = 1'b1;
               state_in = ST_EV_MAG;
            end
         end
         ST_APPLY: begin
            base_in[p_axis]     = base_clamp;
            ev_out_in[axis_ff]  = res_clamp;
            adj_out_in[axis_ff] = 1'b1;
            first_in[axis_ff]   = 1'b1;
            if (axis_ff) begin
               state_in = ST_OUT;
            end else begin
               axis_in  = 1'b1;
               state_in = ST_EV_MAG;
            end
         end
         ST_OUT: begin
            // hand the result word over once the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_cal_in    = cal_flag_ff;
               rsp_vaxis_in  = vidx_ff;
               rsp_ev_in[0]  = cal_flag_ff ? '0 : ev_out_ff[0];
               rsp_ev_in[1]  = cal_flag_ff ? '0 : ev_out_ff[1];
               rsp_adj_in[0] = cal_flag_ff ? 1'b0 : adj_out_ff[0];
               rsp_adj_in[1] = cal_flag_ff ? 1'b0 : adj_out_ff[1];
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      axis_ff      <= axis_in;
      cal_axis_ff  <= cal_axis_in;
      cal_flag_ff  <= cal_flag_in;
      s_ff         <= s_in;
      now_ff       <= now_in;
      mag_ff       <= mag_in;
      den_ff       <= den_in;
      qbits_ff     <= qbits_in;
      neg_ff       <= neg_in;
      e_ff         <= e_in;
      mean_ff      <= mean_in;
      ev_out_ff    <= ev_out_in;
      adj_out_ff   <= adj_out_in;
      rsp_cal_ff   <= rsp_cal_in;
      rsp_vaxis_ff <= rsp_vaxis_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_adj_ff   <= rsp_adj_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hold_ff      <= HOLD_RESET;
         thr_ff       <= THR_RESET;
         cal_cnt_ff   <= '0;
         vidx_ff      <= AXIS_Z;
         for (int k = 0; k < 3; k++) begin
            cal_sum_ff[k] <= '0;
            base_ff[k]    <= '0;
         end
         for (int k = 0; k < 2; k++) begin
            first_ff[k] <= 1'b1;
            prior_ff[k] <= '0;
            rsum_ff[k]  <= '0;
            rcnt_ff[k]  <= '0;
            chg_ff[k]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hold_ff      <= hold_in;
         thr_ff       <= thr_in;
         cal_cnt_ff   <= cal_cnt_in;
         vidx_ff      <= vidx_in;
         cal_sum_ff   <= cal_sum_in;
         base_ff      <= base_in;
         first_ff     <= first_in;
         prior_ff     <= prior_in;
         rsum_ff      <= rsum_in;
         rcnt_ff      <= rcnt_in;
         chg_ff       <= chg_in;
      end
   end

   // result channel
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.calibrating     = rsp_cal_ff;
   assign rsp_ch.vertical_axis   = rsp_vaxis_ff;
   assign rsp_ch.event_first     = rsp_ev_ff[0];
   assign rsp_ch.event_second    = rsp_ev_ff[1];
   assign rsp_ch.adjusted_first  = rsp_adj_ff[0];
   assign rsp_ch.adjusted_second = rsp_adj_ff[1];

`ifndef SYNTH
   a_cal_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cal_cnt_ff <= CAL_CNT_W'(CAL_SAMPLES))
      else $error("calibration count ran past its end");

   a_run_open: assert property (@(posedge clock) disable iff (reset)
      (first_ff[0] || rcnt_ff[0] != '0) && (first_ff[1] || rcnt_ff[1] != '0))
      else $error("open run with zero count");

   a_base_bound: assert property (@(posedge clock) disable iff (reset)
      base_ff[0] <= BASE_LIM && base_ff[0] >= -BASE_LIM &&
      base_ff[1] <= BASE_LIM && base_ff[1] >= -BASE_LIM &&
      base_ff[2] <= BASE_LIM && base_ff[2] >= -BASE_LIM)
      else $error("baseline outside its bound");

   a_cal_word_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cal_ff) |->
         (rsp_ev_ff[0] == '0 && rsp_ev_ff[1] == '0 && !rsp_adj_ff[0] && !rsp_adj_ff[1]))
      else $error("calibration word carries event data");
`endif

endmodule

// File: rtl/core/abdt_div.sv
// Bit-serial restoring divider, rounding half away from zero on a magnitude.
// Depends on abdt_pkg for widths and the request/response structs.
module abdt_div
   import abdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int SH_W = $clog2(N_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  dsr_ff, dsr_in;
   logic [N_W-1:0]    num_ff, num_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [N_W-1:0]    dividend;
   logic [REM_W:0]    trial;
   logic              take;

   // 2*mag + den over 2*den gives the rounded quotient; one bit per cycle
   always_comb begin
      dividend = N_W'({req.mag, 1'b0}) + N_W'(req.den);
      trial    = {rem_ff, num_ff[N_W-1]};
      take     = trial >= {1'b0, dsr_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      num_in   = num_ff;
      quot_in  = quot_ff;
      if (req.start) begin
         // high part lands straight in the remainder, low qbits shift in
         busy_in = 1'b1;
         cnt_in  = req.qbits;
         rem_in  = REM_W'(dividend >> req.qbits);
         num_in  = dividend << (SH_W'(N_W) - SH_W'(req.qbits));
         quot_in = '0;
         dsr_in  = {req.den, 1'b0};
      end else if (busy_ff) begin
         rem_in  = take ? REM_W'(trial - {1'b0, dsr_ff}) : REM_W'(trial);
         num_in  = {num_ff[N_W-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_W-2:0], take};
         cnt_in  = cnt_ff - QCNT_W'(1);
         if (cnt_ff == QCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_qbits_range: assert property (@(posedge clock) disable iff (reset)
      req.start |-> (req.qbits != '0 && req.qbits <= QCNT_W'(QUOT_W)))
      else $error("divider quotient length out of range");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < dsr_ff)
      else $error("partial remainder not below divisor");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("done without a running division");
`endif

endmodule

// File: dv/abdt_checker.sv
// Watches the sample and result channels of the drift tracker, predicts every
// result word from its own copy of the tracker state and compares field by field.
// Depends on abdt_pkg and the channel interfaces in abdt_if.
module abdt_checker
   import abdt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   abdt_req_if                   req_ch,
   abdt_rsp_if                   rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    fail_count,
   output int                    outstanding,
   output int                    words_checked,
   output int                    recentres
);

   typedef struct packed {
      logic                      calibrating;
      logic [1:0]                vertical_axis;
      logic signed [EVENT_W-1:0] event_first;
      logic signed [EVENT_W-1:0] event_second;
      logic                      adjusted_first;
      logic                      adjusted_second;
   } tracker_word_t;

   // shadow registers
   logic [HOLD_W-1:0] hold_s;
   logic [THR_W-1:0]  thr_mg;

   // tracker state: calibration, baselines in 1/256 mg, per-horizontal runs
   int unsigned      cal_n;
   int               cal_acc[3];
   int               base_fix[3];
   logic [1:0]       vert;
   logic             fresh[2];
   int               last_ev[2];
   int               run_acc[2];
   int unsigned      run_n[2];
   logic [SEC_W-1:0] since[2];

   tracker_word_t words_due[$];
   int mismatch_total = 0;
   int checked_total  = 0;
   int recentre_total = 0;

   // division rounded half away from zero; den positive
   function automatic longint half_away_div(longint num, longint den);
      longint mag, q;
      if (den <= 0) return 0;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_total++;
      if (mismatch_total <= 40) $display("MISMATCH: %s", msg);
   endtask

   task automatic clear_tracker();
      hold_s = HOLD_RESET;
      thr_mg = THR_RESET;
      cal_n  = 0;
      vert   = AXIS_Z;
      for (int a = 0; a < 3; a++) begin
         cal_acc[a]  = 0;
         base_fix[a] = 0;
      end
      for (int i = 0; i < 2; i++) begin
         fresh[i]   = 1'b1;
         last_ev[i] = 0;
         run_acc[i] = 0;
         run_n[i]   = 0;
         since[i]   = '0;
      end
   endtask

   // one sample word in, one result word out
   task automatic predict_tracker_word(
      input  logic signed [SAMPLE_W-1:0] sx,
      input  logic signed [SAMPLE_W-1:0] sy,
      input  logic signed [SAMPLE_W-1:0] sz,
      input  logic [SEC_W-1:0]           now_s,
      output tracker_word_t              w);
      int s[3];
      int p;
      int e;
      longint d, res, mean, lim, mag;
      logic [SEC_W-1:0] elapsed;
      logic adj;
      s[0] = sx;
      s[1] = sy;
      s[2] = sz;
      w = '0;
      if (cal_n < CAL_SAMPLES) begin
         for (int a = 0; a < 3; a++) cal_acc[a] += s[a];
         cal_n++;
         // last calibration word: baselines and vertical axis settle now
         if (cal_n >= CAL_SAMPLES) begin
            lim  = longint'(thr_mg) * 256;
            vert = AXIS_Z;
            for (int a = 0; a < 3; a++)
               base_fix[a] = int'(half_away_div(longint'(cal_acc[a]) * 256, CAL_SAMPLES));
            for (int a = 0; a < 3; a++) begin
               mag = (base_fix[a] < 0) ? -longint'(base_fix[a]) : longint'(base_fix[a]);
               if (mag > lim) vert = 2'(a);
            end
         end
         w.calibrating   = 1'b1;
         w.vertical_axis = vert;
      end else begin
         w.vertical_axis = vert;
         for (int i = 0; i < 2; i++) begin
            // horizontal axes, lower-numbered first
            if (vert == AXIS_X) p = i + 1;
            else if (vert == AXIS_Y) p = (i == 0) ? 0 : 2;
            else p = i;
            d = longint'(s[p]) * 256 - base_fix[p];
            e = int'(clip(half_away_div(d, 2560), -4096, 4095));
            // run restarts on first use or a sign change; zero never starts one
            if (fresh[i] || (last_ev[i] <= 0 && e > 0) || (last_ev[i] >= 0 && e < 0)) begin
               fresh[i]   = 1'b0;
               since[i]   = now_s;
               run_acc[i] = 0;
               run_n[i]   = 0;
            end
            last_ev[i] = e;
            if (run_n[i] < RCNT_MAX) begin
               run_acc[i] += e;
               run_n[i]++;
            end
            res     = longint'(e) * 256;
            elapsed = now_s - since[i];
            adj     = 1'b0;
            // held long enough: fold the run mean into the baseline
            if (elapsed > SEC_W'(hold_s) && run_n[i] > 0) begin
               mean = half_away_div(longint'(run_acc[i]) * 256, longint'(run_n[i]));
               base_fix[p] = int'(clip(longint'(base_fix[p]) + mean * 10,
                                       -BASE_LIM, BASE_LIM));
               res -= mean;
               fresh[i] = 1'b1;
               adj      = 1'b1;
            end
            res = clip(res, EV_MIN, EV_MAX);
            if (i == 0) begin
               w.event_first    = EVENT_W'(res);
               w.adjusted_first = adj;
            end else begin
               w.event_second    = EVENT_W'(res);
               w.adjusted_second = adj;
            end
         end
      end
   endtask

   // sample at the edge: words accepted, register writes, results compared
   always @(posedge clock) begin
      tracker_word_t want;
      tracker_word_t next_w;
      if (reset) begin
         clear_tracker();
         words_due.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_HOLD) hold_s = HOLD_W'(csr_wr_data);
            else if (csr_index == CSR_THR) thr_mg = THR_W'(csr_wr_data);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (words_due.size() == 0) begin
               report_mismatch($sformatf("result word %0d with nothing expected",
                                         checked_total));
            end else begin
               want = words_due.pop_front();
               if (rsp_ch.calibrating !== want.calibrating)
                  report_mismatch($sformatf("word %0d calibrating %0b, expected %0b",
                     checked_total, rsp_ch.calibrating, want.calibrating));
               if (rsp_ch.vertical_axis !== want.vertical_axis)
                  report_mismatch($sformatf("word %0d vertical_axis %0d, expected %0d",
                     checked_total, rsp_ch.vertical_axis, want.vertical_axis));
               if (rsp_ch.event_first !== want.event_first)
                  report_mismatch($sformatf("word %0d event_first %0d, expected %0d",
                     checked_total, rsp_ch.event_first, want.event_first));
               if (rsp_ch.event_second !== want.event_second)
                  report_mismatch($sformatf("word %0d event_second %0d, expected %0d",
                     checked_total, rsp_ch.event_second, want.event_second));
               if (rsp_ch.adjusted_first !== want.adjusted_first)
                  report_mismatch($sformatf("word %0d adjusted_first %0b, expected %0b",
                     checked_total, rsp_ch.adjusted_first, want.adjusted_first));
               if (rsp_ch.adjusted_second !== want.adjusted_second)
                  report_mismatch($sformatf("word %0d adjusted_second %0b, expected %0b",
                     checked_total, rsp_ch.adjusted_second, want.adjusted_second));
            end
            checked_total++;
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_tracker_word(req_ch.sample_x, req_ch.sample_y, req_ch.sample_z,
                                 req_ch.seconds, next_w);
            words_due.push_back(next_w);
            recentre_total += int'(next_w.adjusted_first) + int'(next_w.adjusted_second);
         end
      end
      fail_count    <= mismatch_total;
      outstanding   <= words_due.size();
      words_checked <= checked_total;
      recentres     <= recentre_total;
   end

endmodule

// File: dv/tb_accel_baseline_drift_tracker.sv
// Testbench top for the drift tracker: clock, reset, sample stimulus, receiver
// stalls, register writes and the verdict. Depends on abdt_pkg, abdt_if,
// the tracker RTL and abdt_checker.
module tb_accel_baseline_drift_tracker;
   import abdt_pkg::*;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   abdt_req_if req_ch ();
   abdt_rsp_if rsp_ch ();

   int fail_count, outstanding, words_checked, recentres;
   int tx_idle_pct = 12;
   int rx_idle_pct = 86;
   int words_sent  = 0;
   logic [SEC_W-1:0] now_s = '0;
   int xc, yc, zc;

   accel_baseline_drift_tracker DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   abdt_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .words_checked (words_checked),
      .recentres     (recentres)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // run limit
   initial begin
      #10_000_000;
      $display("Timeout with %0d result words outstanding", outstanding);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int clamp_mg(int v);
      if (v > 16383) return 16383;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic int any_mg();
      return int'($urandom_range(32767)) - 16384;
   endfunction

   // offset from the centre: near zero, moderate or large
   function automatic int pick_offset();
      int m;
      case ($urandom_range(2))
         0: m = $urandom_range(8);
         1: m = $urandom_range(10, 500);
         default: m = $urandom_range(500, 20000);
      endcase
      return $urandom_range(1) ? m : -m;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // one sample word, after an optional random gap
   task automatic send_sample(input int x, input int y, input int z,
                              input logic [SEC_W-1:0] sec);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_ch.valid    <= 1'b1;
      req_ch.sample_x <= SAMPLE_W'(x);
      req_ch.sample_y <= SAMPLE_W'(y);
      req_ch.sample_z <= SAMPLE_W'(z);
      req_ch.seconds  <= sec;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   // hold the sender until every expected result word is back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // segments of same-sign offsets with seconds that mostly advance slowly, plus noise
   task automatic drive_drift(input int n_words);
      int k, seg_len, off_x, off_z, r;
      k = 0;
      while (k < n_words) begin
         if ($urandom_range(9) == 0) begin
            send_sample(any_mg(), any_mg(), any_mg(), $urandom());
            k++;
         end else begin
            seg_len = $urandom_range(3, 24);
            off_x   = pick_offset();
            off_z   = pick_offset();
            for (int j = 0; j < seg_len && k < n_words; j++) begin
               r = $urandom_range(99);
               if (r < 3) now_s = now_s + $urandom_range(200, 700);
               else if (r < 5) now_s = now_s - $urandom_range(1, 50);
               else if (r < 40) now_s = now_s + 1;
               send_sample(clamp_mg(xc + off_x + int'($urandom_range(6)) - 3),
                           clamp_mg(yc + int'($urandom_range(40)) - 20),
                           clamp_mg(zc + off_z + int'($urandom_range(6)) - 3),
                           now_s);
               k++;
            end
         end
      end
   endtask

   initial begin
      int thr, x_mean, y_mean, zd, x, y, z, hold_last, drain_cycles;
      longint x_sum;
      req_ch.valid    = 1'b0;
      req_ch.sample_x = '0;
      req_ch.sample_y = '0;
      req_ch.sample_z = '0;
      req_ch.seconds  = '0;
      rsp_ch.ready    = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // threshold chosen so that x and y exceed it and z sits exactly on it
      thr = $urandom_range(300, 900);
      write_reg(CSR_THR, thr);
      write_reg(CSR_HOLD, 2);
      x_mean = thr + $urandom_range(100, 3000);
      y_mean = -(thr + int'($urandom_range(100, 3000)));
      x_sum  = 0;
      zd     = 0;
      for (int k = 0; k < CAL_SAMPLES; k++) begin
         if (k == 0) begin
            x = 16383;
            y = -16384;
         end else if (k == 1) begin
            x = -16384;
            y = 16383;
         end else begin
            x = x_mean + int'($urandom_range(800)) - 400;
            y = y_mean + int'($urandom_range(800)) - 400;
         end
         // z in cancelling pairs, so its mean is exactly the threshold
         if (k % 2 == 0) zd = int'($urandom_range(200)) - 100;
         z = (k % 2 == 0) ? thr + zd : thr - zd;
         x_sum += x;
         send_sample(x, y, z, SEC_W'(k / 127));
      end
      xc = int'(x_sum / CAL_SAMPLES);
      yc = y_mean;
      zc = thr;

      // directed: half-way rounding on z, a hold ending in re-centring,
      // extremes, timestamps going backwards and wrapping
      send_sample(xc, yc, zc, 32'd1000);
      send_sample(xc + 200, yc, zc + 5, 32'd1000);
      send_sample(xc + 300, yc, zc + 15, 32'd1001);
      send_sample(xc + 250, yc, zc - 5, 32'd1002);
      send_sample(xc + 280, yc, zc - 15, 32'd1003);
      send_sample(xc + 280, yc, zc - 25, 32'd1006);
      send_sample(xc + 280, yc, zc - 25, 32'd1006);
      send_sample(xc, yc, zc, 32'd1006);
      send_sample(xc + 40, yc, zc + 40, 32'd1007);
      send_sample(16383, -16384, 16383, 32'd1008);
      send_sample(-16384, 16383, -16384, 32'd1008);
      send_sample(-16384, -16384, -16384, 32'd0);
      send_sample(16383, 16383, 16383, 32'hFFFF_FFFF);
      send_sample(16383, 16383, 16383, 32'h0000_0000);
      send_sample(xc, yc, zc, 32'h8000_0000);
      send_sample(0, 0, 0, 32'h7FFF_FFFF);
      send_sample(xc - 300, yc, zc - 300, 32'h7FFF_FFFF);
      send_sample(xc - 300, yc, zc - 300, 32'h8000_0001);

      // re-centre whenever a second passes
      wait_idle();
      write_reg(CSR_HOLD, 0);
      now_s = 32'd5000;
      drive_drift(200);

      // longest hold: only jumps and backward steps re-centre
      wait_idle();
      tx_idle_pct = 86;
      rx_idle_pct = 12;
      write_reg(CSR_HOLD, 255);
      write_reg(CSR_THR, 16383);
      drive_drift(100);
      wait_idle();
      drive_drift(100);

      // short hold, no idling, seconds wrapping
      wait_idle();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_last = $urandom_range(1, 8);
      write_reg(CSR_HOLD, hold_last);
      write_reg(CSR_THR, 0);
      now_s = 32'hFFFF_FF00;
      drive_drift(200);

      // drain, then let any stray word show up
      req_ch.valid <= 1'b0;
      drain_cycles = 0;
      do begin
         @(posedge clock);
         drain_cycles++;
      end while (outstanding != 0 && drain_cycles < 50000);
      repeat (100) @(posedge clock);

      if (outstanding != 0)
         $display("%0d result words never arrived", outstanding);
      $display("Covered %0d calibration words and %0d tracking words, hold 2, 0, 255, %0d.",
               CAL_SAMPLES, words_sent - CAL_SAMPLES, hold_last);
      $display("%0d result words checked, %0d baseline re-centres, %0d mismatches.",
               words_checked, recentres, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
